/* rtl/core/bqr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad ramp package
// Shared constants, register indexes and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package bqr_pkg;

   localparam int STATE_BITS = 48;
   localparam int GUARD_BITS = 12;
   localparam int NUM_COEFS  = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int RAMP_W     = 4;

   localparam logic [RAMP_W-1:0] RAMP_RESET = 4'd6;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_B1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_B2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_A1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_A2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_LOG2 = 3'd5;

   typedef enum logic [2:0] {
      COEF_B0 = 3'd0,
      COEF_B1 = 3'd1,
      COEF_B2 = 3'd2,
      COEF_A1 = 3'd3,
      COEF_A2 = 3'd4
   } coef_idx_type;

   typedef struct packed {
      logic         load;
      logic         coef_upd;
      logic         mul_en;
      coef_idx_type coef_sel;
      logic         use_y;
      logic         y_write;
      logic         t1_write;
      logic         t2_write;
      logic         d1_write;
      logic         d2_write;
   } cmd_type;

endpackage
`default_nettype wire

/* rtl/core/bqr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad ramp controller
// Sequences one sample through coefficient update, five products and write-back.
// ----------------------------------------------------------------------------
module bqr_ctrl
   import bqr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output cmd_type      cmd
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_COEF = 8'b0000_0010,
      ST_MB0  = 8'b0000_0100,
      ST_MB1  = 8'b0000_1000,
      ST_MB2  = 8'b0001_0000,
      ST_MA1  = 8'b0010_0000,
      ST_MA2  = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_COEF;
            end
         end
         ST_COEF: begin
            cmd.coef_upd = 1'b1;
            state_in     = ST_MB0;
         end
         ST_MB0: begin
            cmd.mul_en   = 1'b1;
            cmd.coef_sel = COEF_B0;
            state_in     = ST_MB1;
         end
         ST_MB1: begin
            // hold here until the word register is free
            if (out_free) begin
               cmd.mul_en   = 1'b1;
               cmd.coef_sel = COEF_B1;
               cmd.y_write  = 1'b1;
               state_in     = ST_MB2;
            end
         end
         ST_MB2: begin
            cmd.mul_en   = 1'b1;
            cmd.coef_sel = COEF_B2;
            cmd.t1_write = 1'b1;
            state_in     = ST_MA1;
         end
         ST_MA1: begin
            cmd.mul_en   = 1'b1;
            cmd.coef_sel = COEF_A1;
            cmd.use_y    = 1'b1;
            cmd.t2_write = 1'b1;
            state_in     = ST_MA2;
         end
         ST_MA2: begin
            cmd.mul_en   = 1'b1;
            cmd.coef_sel = COEF_A2;
            cmd.use_y    = 1'b1;
            cmd.d1_write = 1'b1;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            cmd.d2_write = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.y_write || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* rtl/core/bqr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad ramp datapath
// Coefficient glide, shared multiplier, delay states and result register.
// ----------------------------------------------------------------------------
module bqr_dp
   import bqr_pkg::*;
#(
   parameter int SAMPLE_BITS   = 24,
   parameter int COEF_BITS     = 32,
   parameter int MAX_RAMP_LOG2 = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cmd_type                       cmd,
   input  wire logic                          csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [COEF_BITS-1:0]          csr_wdata,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  wire logic                          req_clear_state,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out
);

   localparam int K_W       = (MAX_RAMP_LOG2 < 1) ? 1 : $clog2(MAX_RAMP_LOG2 + 1);
   localparam int POS_W     = (MAX_RAMP_LOG2 < 1) ? 1 : MAX_RAMP_LOG2;
   localparam int PROD_W    = SAMPLE_BITS + COEF_BITS;
   localparam int MUL_SHIFT = COEF_BITS - 16;
   localparam int SH_W      = PROD_W - MUL_SHIFT;
   localparam int ACC_W     = STATE_BITS + 2;
   localparam int YSH_W     = ACC_W - GUARD_BITS;

   localparam logic signed [COEF_BITS-1:0] COEF_ONE =
      {3'b000, 1'b1, {(COEF_BITS-4){1'b0}}};
   localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
   localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [ACC_W-1:0] v
   );
      logic fits;
      fits = (v[ACC_W-1:STATE_BITS-1] == {(ACC_W-STATE_BITS+1){v[ACC_W-1]}});
      if (fits) begin
         return v[STATE_BITS-1:0];
      end else if (v[ACC_W-1]) begin
         return {1'b1, {(STATE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(STATE_BITS-1){1'b1}}};
      end
   endfunction

   // architectural state
   logic signed [COEF_BITS-1:0]   target_ff [NUM_COEFS];
   logic signed [COEF_BITS-1:0]   live_ff   [NUM_COEFS];
   logic signed [COEF_BITS-1:0]   step_ff   [NUM_COEFS];
   logic [RAMP_W-1:0]             ramp_ff;
   logic [POS_W-1:0]              pos_ff;
   logic signed [STATE_BITS-1:0]  d1_ff, d2_ff;

   // per-sample working registers
   logic signed [SAMPLE_BITS-1:0] x_ff, y_ff;
   logic signed [PROD_W-1:0]      p_ff;
   logic signed [ACC_W-1:0]       t1_ff, t2_ff;

   // coefficient glide
   logic [K_W-1:0]                k_val;
   logic [POS_W-1:0]              len_m1;
   logic                          last;
   logic signed [COEF_BITS:0]     diff     [NUM_COEFS];
   logic signed [COEF_BITS:0]     diff_sh  [NUM_COEFS];
   logic signed [COEF_BITS-1:0]   step_in  [NUM_COEFS];
   logic signed [COEF_BITS:0]     sum      [NUM_COEFS];
   logic signed [COEF_BITS-1:0]   live_in  [NUM_COEFS];

   // filter arithmetic
   logic signed [SAMPLE_BITS-1:0] mul_a;
   logic signed [COEF_BITS-1:0]   mul_c;
   logic signed [PROD_W-1:0]      prod_full;
   logic signed [SH_W-1:0]        prod_sh;
   logic signed [ACC_W-1:0]       prod_ext, d1_ext, d2_ext;
   logic signed [ACC_W-1:0]       acc_y, t1_in, d1_sum, d2_sum;
   logic [YSH_W-1:0]              acc_sh;
   logic signed [SAMPLE_BITS-1:0] y_in;

   assign k_val  = (int'(ramp_ff) > MAX_RAMP_LOG2) ? K_W'(MAX_RAMP_LOG2) : K_W'(ramp_ff);
   assign len_m1 = ~({POS_W{1'b1}} << k_val);
   assign last   = (pos_ff >= len_m1);

   always_comb begin
      for (int i = 0; i < NUM_COEFS; i++) begin
         diff[i]    = $signed({target_ff[i][COEF_BITS-1], target_ff[i]})
                    - $signed({live_ff[i][COEF_BITS-1], live_ff[i]});
         diff_sh[i] = diff[i] >>> k_val;
         step_in[i] = diff_sh[i][COEF_BITS-1:0];
         sum[i]     = $signed({live_ff[i][COEF_BITS-1], live_ff[i]})
                    + $signed({step_ff[i][COEF_BITS-1], step_ff[i]});
         if (last) begin
            live_in[i] = target_ff[i];
         end else if (sum[i][COEF_BITS] != sum[i][COEF_BITS-1]) begin
            live_in[i] = sum[i][COEF_BITS] ? COEF_MIN : COEF_MAX;
         end else begin
            live_in[i] = sum[i][COEF_BITS-1:0];
         end
      end
   end

   assign mul_a     = cmd.use_y ? y_ff : x_ff;
   assign mul_c     = live_ff[cmd.coef_sel];
   assign prod_full = mul_a * mul_c;

   assign prod_sh  = p_ff[PROD_W-1:MUL_SHIFT];
   assign prod_ext = $signed({{(ACC_W-SH_W){prod_sh[SH_W-1]}}, prod_sh});
   assign d1_ext   = $signed({{(ACC_W-STATE_BITS){d1_ff[STATE_BITS-1]}}, d1_ff});
   assign d2_ext   = $signed({{(ACC_W-STATE_BITS){d2_ff[STATE_BITS-1]}}, d2_ff});

   assign acc_y  = prod_ext + d1_ext;
   assign acc_sh = acc_y[ACC_W-1:GUARD_BITS];
   assign t1_in  = prod_ext + d2_ext;
   assign d1_sum = t1_ff - prod_ext;
   assign d2_sum = t2_ff - prod_ext;

   always_comb begin
      if (acc_sh[YSH_W-1:SAMPLE_BITS-1] == {(YSH_W-SAMPLE_BITS+1){acc_sh[YSH_W-1]}}) begin
         y_in = acc_sh[SAMPLE_BITS-1:0];
      end else if (acc_sh[YSH_W-1]) begin
         y_in = SMP_MIN;
      end else begin
         y_in = SMP_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            target_ff[i] <= (i == 0) ? COEF_ONE : '0;
            live_ff[i]   <= (i == 0) ? COEF_ONE : '0;
            step_ff[i]   <= '0;
         end
         ramp_ff <= RAMP_RESET;
         pos_ff  <= '0;
         d1_ff   <= '0;
         d2_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index) inside
               [CSR_TARGET_B0:CSR_TARGET_A2]: target_ff[csr_index] <= csr_wdata;
               CSR_RAMP_LOG2:                 ramp_ff <= csr_wdata[RAMP_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            // new steps only at the start of a block
            if (pos_ff == '0) begin
               for (int i = 0; i < NUM_COEFS; i++) begin
                  step_ff[i] <= step_in[i];
               end
            end
            if (req_clear_state) begin
               d1_ff <= '0;
               d2_ff <= '0;
            end
         end
         if (cmd.coef_upd) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
               live_ff[i] <= live_in[i];
            end
            pos_ff <= last ? '0 : pos_ff + 1'b1;
         end
         if (cmd.d1_write) begin
            d1_ff <= sat_state(d1_sum);
         end
         if (cmd.d2_write) begin
            d2_ff <= sat_state(d2_sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_sample_in;
      end
      if (cmd.mul_en) begin
         p_ff <= prod_full;
      end
      if (cmd.y_write) begin
         y_ff <= y_in;
      end
      if (cmd.t1_write) begin
         t1_ff <= t1_in;
      end
      if (cmd.t2_write) begin
         t2_ff <= prod_ext;
      end
   end

   assign rsp_sample_out = y_ff;

endmodule
`default_nettype wire

/* rtl/core/biquad_tdf2_coefficient_ramp_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Biquad filter with coefficient ramp
// Transposed direct form II biquad whose live coefficients glide to targets.
// ----------------------------------------------------------------------------
// One signed sample word enters on the req_ channel and one saturated filtered
// word leaves on the rsp_ channel. An accepted sample first steps the five
// live coefficients, then runs five products through a single shared
// multiplier (b0, b1, b2 on the input, a1, a2 on the output) with the delay
// states written back behind them. The result word is registered and is
// written in the step after the b0 product. A new sample is taken as soon
// as the previous one has written its states back, even while its result
// still waits. A stalled result only holds the sequencer when the next
// result is ready to overwrite it. Targets and ramp_log2 are to be written
// on the csr_ port only while the block is idle; the block does not enforce it.
// The glide toward the targets runs in blocks of 2^ramp_log2 samples, with
// ramp_log2 capped at MAX_RAMP_LOG2, and the last sample of each block loads
// the targets exactly. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module biquad_tdf2_coefficient_ramp_top
   import bqr_pkg::*;
#(
   parameter int SAMPLE_BITS   = 24,
   parameter int COEF_BITS     = 32,
   parameter int MAX_RAMP_LOG2 = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // sample input channel
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  wire logic                          req_clear_state,
   // filtered sample channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   // register write port
   input  wire logic                          csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [COEF_BITS-1:0]          csr_wdata
);

   cmd_type cmd;

   // sequencer: owns the handshakes and drives the datapath commands
   bqr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // arithmetic, coefficient glide and all filter state
   bqr_dp #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .COEF_BITS     (COEF_BITS),
      .MAX_RAMP_LOG2 (MAX_RAMP_LOG2)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_sample_in   (req_sample_in),
      .req_clear_state (req_clear_state),
      .rsp_sample_out  (rsp_sample_out)
   );

   // a new result never overwrites a word that is still waiting
   a_result_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.y_write |-> (!rsp_valid || !rsp_stall))
      else $error("result written over a stalled word");

   // the coefficient step always directly follows the sample load
   a_coef_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.coef_upd |-> $past(cmd.load))
      else $error("coefficient update without a preceding load");

   // each sequencer step commits at most one kind of state write
   a_single_commit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.coef_upd, cmd.y_write, cmd.t1_write,
                cmd.t2_write, cmd.d1_write, cmd.d2_write}))
      else $error("overlapping datapath writes");

endmodule
`default_nettype wire
